/* rtl/core/scm_pkg.sv */
// Shared types and constants of the stereo correlation meter.
package scm_pkg;

    localparam int COEFF_W             = 25;
    localparam int FILT_W              = 32;
    localparam int AVG_W               = 48;
    localparam int CORR_W              = 16;
    localparam int PROD_SHIFT          = 16;
    localparam int HALF_W              = 24;
    localparam int ACC_W               = 96;
    localparam int CMP_W               = 127;
    localparam int LIN_W               = 112;
    localparam int ROOT_W              = 17;
    localparam int WIDE_W              = 80;
    localparam int DEF_SAMPLE_BITS     = 16;
    localparam int DEF_COEFF_FRAC_BITS = 24;
    localparam int APB_ADDR_W          = 3;
    localparam int APB_DATA_W          = 32;

    localparam logic [COEFF_W-1:0] LOWPASS_RESET = 25'd4392269;
    localparam logic [COEFF_W-1:0] FALLOFF_RESET = 25'd2330;

    localparam logic [APB_ADDR_W-1:0] ADDR_LOWPASS = 3'd0;
    localparam logic [APB_ADDR_W-1:0] ADDR_FALLOFF = 3'd4;

    typedef struct packed {
        logic [COEFF_W-1:0] lowpass;
        logic [COEFF_W-1:0] falloff;
    } t_coeffs;

    typedef enum logic [4:0] {
        S_IDLE, S_LP_L, S_LP_R, S_PX, S_PL, S_PR,
        S_AX_H, S_AX_L, S_AL_H, S_AL_L, S_AR_H, S_AR_L,
        S_P0, S_P1, S_P2, S_P3, S_C0, S_C1, S_C2, S_C3,
        S_FULL, S_SA, S_SB, S_DONE
    } t_state;

endpackage

/* rtl/core/scm_cfg.sv */
// Coefficient registers behind the APB configuration port.
module scm_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [scm_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [scm_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [scm_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output scm_pkg::t_coeffs                  o_coeffs
);
    import scm_pkg::*;

    logic [COEFF_W-1:0] r_lowpass;
    logic [COEFF_W-1:0] r_falloff;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lowpass <= LOWPASS_RESET;
            r_falloff <= FALLOFF_RESET;
        end else if (wr_en) begin
            if (paddr == ADDR_LOWPASS) begin
                r_lowpass <= pwdata[COEFF_W-1:0];
            end
            if (paddr == ADDR_FALLOFF) begin
                r_falloff <= pwdata[COEFF_W-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_LOWPASS) begin
            prdata = APB_DATA_W'(r_lowpass);
        end else if (paddr == ADDR_FALLOFF) begin
            prdata = APB_DATA_W'(r_falloff);
        end
    end

    assign o_coeffs.lowpass = r_lowpass;
    assign o_coeffs.falloff = r_falloff;

endmodule

/* rtl/core/scm_front.sv */
// Input stage: accepts sample pairs into a two-entry queue.
module scm_front #(
    parameter int SAMPLE_BITS = scm_pkg::DEF_SAMPLE_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [2*SAMPLE_BITS:0]  i_data,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [2*SAMPLE_BITS:0]  o_data
);
    import scm_pkg::*;

    logic [2*SAMPLE_BITS:0] r_mem [2];
    logic                   r_wptr;
    logic                   r_rptr;
    logic [1:0]             r_count;
    logic                   push;
    logic                   pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign push    = i_valid & o_ready;
    assign pop     = o_valid & i_ready;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + 2'(push) - 2'(pop);
        end
    end

endmodule

/* rtl/core/scm_back.sv */
// Sequenced datapath: filters, averages, root search and the result register.
module scm_back #(
    parameter int SAMPLE_BITS     = scm_pkg::DEF_SAMPLE_BITS,
    parameter int COEFF_FRAC_BITS = scm_pkg::DEF_COEFF_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  scm_pkg::t_coeffs              i_coeffs,
    input  logic                          i_q_valid,
    output logic                          o_q_ready,
    input  logic [2*SAMPLE_BITS:0]        i_q_data,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [scm_pkg::CORR_W-1:0]    o_m_tdata
);
    import scm_pkg::*;

    localparam int PAD = FILT_W - SAMPLE_BITS;

    t_state r_state, n_state;
    logic   r_phase, n_phase;

    logic signed [FILT_W-1:0] r_xl, n_xl, r_xr, n_xr;
    logic signed [FILT_W-1:0] r_lf, n_lf, r_rf, n_rf;
    logic signed [AVG_W-1:0]  r_px, n_px, r_pl, n_pl, r_pr, n_pr;
    logic signed [AVG_W-1:0]  r_ca, n_ca, r_la, n_la, r_ra, n_ra;
    logic signed [64:0]       r_prod, n_prod, r_acc, n_acc;
    logic [ACC_W-1:0]         r_pp, n_pp, r_cc, n_cc;
    logic [CMP_W-1:0]         r_q, n_q, r_t, n_t;
    logic [LIN_W-1:0]         r_r, n_r;
    logic [ROOT_W-1:0]        r_c, n_c;
    logic [3:0]               r_k, n_k;
    logic                     r_ovalid, n_ovalid;
    logic [CORR_W-1:0]        r_odata, n_odata;

    logic signed [32:0]       m_a;
    logic signed [31:0]       m_b;
    logic signed [AVG_W:0]    d_avg;
    logic signed [AVG_W-1:0]  a_cur;
    logic signed [WIDE_W-1:0] avg_full;
    logic signed [AVG_W-1:0]  avg_new;
    logic signed [FILT_W-1:0] f_cur;
    logic signed [FILT_W-1:0] f_new;
    logic [AVG_W-1:0]         mag;
    logic [CMP_W-1:0]         c_big;
    logic [CMP_W-1:0]         trial;
    logic [ACC_W-1:0]         pp_add;
    logic [CORR_W-1:0]        res;
    logic                     pow_ok;

    function automatic logic signed [FILT_W-1:0] sat_filt(input logic signed [WIDE_W-1:0] v);
        if (v[WIDE_W-1:FILT_W-1] == '0 || v[WIDE_W-1:FILT_W-1] == '1) begin
            return v[FILT_W-1:0];
        end
        return v[WIDE_W-1] ? {1'b1, {(FILT_W-1){1'b0}}} : {1'b0, {(FILT_W-1){1'b1}}};
    endfunction

    function automatic logic signed [AVG_W-1:0] sat_avg(input logic signed [WIDE_W-1:0] v);
        if (v[WIDE_W-1:AVG_W-1] == '0 || v[WIDE_W-1:AVG_W-1] == '1) begin
            return v[AVG_W-1:0];
        end
        return v[WIDE_W-1] ? {1'b1, {(AVG_W-1){1'b0}}} : {1'b0, {(AVG_W-1){1'b1}}};
    endfunction

    assign mag    = r_ca[AVG_W-1] ? AVG_W'(-r_ca) : r_ca;
    assign c_big  = CMP_W'(r_cc) << 30;
    assign pow_ok = !r_la[AVG_W-1] && (r_la != '0) && !r_ra[AVG_W-1] && (r_ra != '0);
    assign n_prod = m_a * m_b;

    always_comb begin
        m_a   = '0;
        m_b   = '0;
        d_avg = '0;
        a_cur = r_ca;
        f_cur = r_lf;
        unique case (r_state)
            S_LP_L: begin
                m_a = 33'(r_xl) - 33'(r_lf);
                m_b = $signed(32'(i_coeffs.lowpass));
            end
            S_LP_R: begin
                f_cur = r_rf;
                m_a   = 33'(r_xr) - 33'(r_rf);
                m_b   = $signed(32'(i_coeffs.lowpass));
            end
            S_PX: begin
                m_a = 33'(r_lf);
                m_b = r_rf;
            end
            S_PL: begin
                m_a = 33'(r_lf);
                m_b = r_lf;
            end
            S_PR: begin
                m_a = 33'(r_rf);
                m_b = r_rf;
            end
            S_AX_H, S_AX_L, S_AL_H, S_AL_L, S_AR_H, S_AR_L: begin
                if (r_state == S_AX_H || r_state == S_AX_L) begin
                    d_avg = 49'(r_px) - 49'(r_ca);
                    a_cur = r_ca;
                end else if (r_state == S_AL_H || r_state == S_AL_L) begin
                    d_avg = 49'(r_pl) - 49'(r_la);
                    a_cur = r_la;
                end else begin
                    d_avg = 49'(r_pr) - 49'(r_ra);
                    a_cur = r_ra;
                end
                if (r_state == S_AX_H || r_state == S_AL_H || r_state == S_AR_H) begin
                    m_a = 33'($signed(d_avg[AVG_W:HALF_W]));
                end else begin
                    m_a = $signed({9'b0, d_avg[HALF_W-1:0]});
                end
                m_b = $signed(32'(i_coeffs.falloff));
            end
            S_P0: begin
                m_a = $signed({9'b0, r_la[HALF_W-1:0]});
                m_b = $signed({8'b0, r_ra[HALF_W-1:0]});
            end
            S_P1: begin
                m_a = $signed({9'b0, r_la[HALF_W-1:0]});
                m_b = $signed({8'b0, r_ra[AVG_W-1:HALF_W]});
            end
            S_P2: begin
                m_a = $signed({9'b0, r_la[AVG_W-1:HALF_W]});
                m_b = $signed({8'b0, r_ra[HALF_W-1:0]});
            end
            S_P3: begin
                m_a = $signed({9'b0, r_la[AVG_W-1:HALF_W]});
                m_b = $signed({8'b0, r_ra[AVG_W-1:HALF_W]});
            end
            S_C0: begin
                m_a = $signed({9'b0, mag[HALF_W-1:0]});
                m_b = $signed({8'b0, mag[HALF_W-1:0]});
            end
            S_C1: begin
                m_a = $signed({9'b0, mag[HALF_W-1:0]});
                m_b = $signed({8'b0, mag[AVG_W-1:HALF_W]});
            end
            S_C2: begin
                m_a = $signed({9'b0, mag[AVG_W-1:HALF_W]});
                m_b = $signed({8'b0, mag[HALF_W-1:0]});
            end
            S_C3: begin
                m_a = $signed({9'b0, mag[AVG_W-1:HALF_W]});
                m_b = $signed({8'b0, mag[AVG_W-1:HALF_W]});
            end
            default: begin
            end
        endcase
    end

    assign f_new    = sat_filt(80'(f_cur) + (80'(r_prod) >>> COEFF_FRAC_BITS));
    assign avg_full = (80'(r_acc) <<< HALF_W) + 80'(r_prod);
    assign avg_new  = sat_avg(80'(a_cur) + (avg_full >>> COEFF_FRAC_BITS));
    assign trial    = r_t + (CMP_W'(r_pp) << {r_k, 1'b0});

    always_comb begin
        pp_add = ACC_W'(r_prod[AVG_W-1:0]);
        if (r_state == S_P1 || r_state == S_P2 || r_state == S_C1 || r_state == S_C2) begin
            pp_add = ACC_W'(r_prod[AVG_W-1:0]) << HALF_W;
        end else if (r_state == S_P3 || r_state == S_C3) begin
            pp_add = ACC_W'(r_prod[AVG_W-1:0]) << AVG_W;
        end
    end

    always_comb begin
        if (r_ca[AVG_W-1]) begin
            res = CORR_W'(-r_c);
        end else if (r_c[CORR_W-1]) begin
            res = {1'b0, {(CORR_W-1){1'b1}}};
        end else begin
            res = r_c[CORR_W-1:0];
        end
    end

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_xl = r_xl;  n_xr = r_xr;  n_lf = r_lf;  n_rf = r_rf;
        n_px = r_px;  n_pl = r_pl;  n_pr = r_pr;
        n_ca = r_ca;  n_la = r_la;  n_ra = r_ra;
        n_acc = r_acc;
        n_pp = r_pp;  n_cc = r_cc;
        n_q  = r_q;   n_t  = r_t;   n_r  = r_r;  n_c = r_c;  n_k = r_k;
        n_ovalid = r_ovalid & ~i_m_tready;
        n_odata  = r_odata;
        o_q_ready = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_q_ready = 1'b1;
                if (i_q_valid) begin
                    n_xl = {i_q_data[SAMPLE_BITS-1:0], {PAD{1'b0}}};
                    n_xr = {i_q_data[2*SAMPLE_BITS-1:SAMPLE_BITS], {PAD{1'b0}}};
                    if (i_q_data[2*SAMPLE_BITS]) begin
                        n_lf = '0;  n_rf = '0;
                        n_ca = '0;  n_la = '0;  n_ra = '0;
                    end
                    n_phase = 1'b0;
                    n_state = S_LP_L;
                end
            end
            S_FULL: begin
                if (r_pp <= r_cc) begin
                    n_c     = {2'b01, {(ROOT_W-2){1'b0}}};
                    n_state = S_DONE;
                end else begin
                    n_q     = '0;
                    n_r     = '0;
                    n_c     = '0;
                    n_k     = 4'd15;
                    n_state = S_SA;
                end
            end
            S_SA: begin
                n_t     = r_q + (CMP_W'(r_r) << (5'(r_k) + 5'd1));
                n_state = S_SB;
            end
            S_SB: begin
                if (trial <= c_big) begin
                    n_q      = trial;
                    n_r      = r_r + (LIN_W'(r_pp) << r_k);
                    n_c[r_k] = 1'b1;
                end
                if (r_k == 4'd0) begin
                    n_state = S_DONE;
                end else begin
                    n_k     = r_k - 4'd1;
                    n_state = S_SA;
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = res;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                if (!r_phase) begin
                    if (r_state == S_P0 && !pow_ok) begin
                        n_c     = '0;
                        n_state = S_DONE;
                    end else begin
                        n_phase = 1'b1;
                    end
                end else begin
                    n_phase = 1'b0;
                    unique case (r_state)
                        S_LP_L: begin n_lf = f_new; n_state = S_LP_R; end
                        S_LP_R: begin n_rf = f_new; n_state = S_PX; end
                        S_PX:   begin n_px = r_prod[63:PROD_SHIFT]; n_state = S_PL; end
                        S_PL:   begin n_pl = r_prod[63:PROD_SHIFT]; n_state = S_PR; end
                        S_PR:   begin n_pr = r_prod[63:PROD_SHIFT]; n_state = S_AX_H; end
                        S_AX_H: begin n_acc = r_prod; n_state = S_AX_L; end
                        S_AX_L: begin n_ca = avg_new; n_state = S_AL_H; end
                        S_AL_H: begin n_acc = r_prod; n_state = S_AL_L; end
                        S_AL_L: begin n_la = avg_new; n_state = S_AR_H; end
                        S_AR_H: begin n_acc = r_prod; n_state = S_AR_L; end
                        S_AR_L: begin n_ra = avg_new; n_state = S_P0; end
                        S_P0:   begin n_pp = pp_add; n_state = S_P1; end
                        S_P1:   begin n_pp = r_pp + pp_add; n_state = S_P2; end
                        S_P2:   begin n_pp = r_pp + pp_add; n_state = S_P3; end
                        S_P3:   begin n_pp = r_pp + pp_add; n_state = S_C0; end
                        S_C0:   begin n_cc = pp_add; n_state = S_C1; end
                        S_C1:   begin n_cc = r_cc + pp_add; n_state = S_C2; end
                        S_C2:   begin n_cc = r_cc + pp_add; n_state = S_C3; end
                        S_C3:   begin n_cc = r_cc + pp_add; n_state = S_FULL; end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= 1'b0;
            r_ovalid <= 1'b0;
            r_lf     <= '0;
            r_rf     <= '0;
            r_ca     <= '0;
            r_la     <= '0;
            r_ra     <= '0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_ovalid <= n_ovalid;
            r_lf     <= n_lf;
            r_rf     <= n_rf;
            r_ca     <= n_ca;
            r_la     <= n_la;
            r_ra     <= n_ra;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xl    <= n_xl;
        r_xr    <= n_xr;
        r_px    <= n_px;
        r_pl    <= n_pl;
        r_pr    <= n_pr;
        r_prod  <= n_prod;
        r_acc   <= n_acc;
        r_pp    <= n_pp;
        r_cc    <= n_cc;
        r_q     <= n_q;
        r_t     <= n_t;
        r_r     <= n_r;
        r_c     <= n_c;
        r_k     <= n_k;
        r_odata <= n_odata;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

endmodule

/* rtl/core/stereo_correlation_meter_top.sv */
// Top level of the stereo correlation meter.
//
// Each sample pair runs the full state sequence when the full correlation is computed, and
// a shorter one when either power average is not positive or the magnitude reaches one.
// Its time is set by the single shared 33 by 32 bit multiplier, which forms the nineteen
// products of an item in turn, and by the root search, which resolves one result bit per step.
// A two-entry input queue and a result register let the stream sides stall independently.
// Coefficients must be written through the APB port only while idle; the block does not check.
module stereo_correlation_meter_top #(
    parameter int SAMPLE_BITS     = scm_pkg::DEF_SAMPLE_BITS,
    parameter int COEFF_FRAC_BITS = scm_pkg::DEF_COEFF_FRAC_BITS,
    parameter int TDATA_W         = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [TDATA_W-1:0]              s_axis_tdata,  // left_sample, right_sample
    input  logic [0:0]                      s_axis_tuser,  // clear_state
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [scm_pkg::CORR_W-1:0]      m_axis_tdata,  // correlation
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [scm_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [scm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [scm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import scm_pkg::*;

    t_coeffs                coeffs;
    logic                   q_valid;
    logic                   q_ready;
    logic [2*SAMPLE_BITS:0] q_data;
    logic [2*SAMPLE_BITS:0] in_data;

    assign in_data = {s_axis_tuser, s_axis_tdata[2*SAMPLE_BITS-1:0]};

    scm_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_coeffs (coeffs)
    );

    scm_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (in_data),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_data)
    );

    scm_back #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_coeffs   (coeffs),
        .i_q_valid  (q_valid),
        .o_q_ready  (q_ready),
        .i_q_data   (q_data),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata)
    );

endmodule
